// ----- hw/rtl/voxel_visible_face_extract_assert.svh -----
// Assertion macros shared by the visible-face extractor modules.
// Depends on nothing; included by the controller and the datapath.
`ifndef VOXEL_VISIBLE_FACE_EXTRACT_ASSERT_SVH
`define VOXEL_VISIBLE_FACE_EXTRACT_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define VVFE_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising clock edge out of reset.
`define VVFE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/vvfe_pkg.sv -----
// Shared types, codes and helper functions of the visible-face extractor.
// Depends on nothing; used by every module of the block but vvfe_ram.
`default_nettype none

package vvfe_pkg;

    // Default grid size.
    localparam int GRID_WIDTH_DEF  = 16;
    localparam int GRID_HEIGHT_DEF = 128;

    // Field widths.
    localparam int CMD_W   = 2;
    localparam int XZ_W    = 4;
    localparam int Y_W     = 7;
    localparam int KIND_W  = 4;
    localparam int FACE_W  = 3;
    localparam int UV_W    = 2;
    localparam int COUNT_W = 18;
    localparam int VBASE_W = COUNT_W + 2;

    // Internal coordinate width, wide enough for a neighbor of any legal cell.
    localparam int COORD_W = 8;

    localparam int NUM_FACES = 6;
    localparam int SRC_W     = 3;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_EMIT    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

    // Face codes, also the emit order.
    localparam logic [FACE_W-1:0] FACE_FRONT  = 3'd0;
    localparam logic [FACE_W-1:0] FACE_BACK   = 3'd1;
    localparam logic [FACE_W-1:0] FACE_RIGHT  = 3'd2;
    localparam logic [FACE_W-1:0] FACE_LEFT   = 3'd3;
    localparam logic [FACE_W-1:0] FACE_TOP    = 3'd4;
    localparam logic [FACE_W-1:0] FACE_BOTTOM = 3'd5;

    // Texture set codes.
    localparam logic [UV_W-1:0] UV_SIDE   = 2'd0;
    localparam logic [UV_W-1:0] UV_TOP    = 2'd1;
    localparam logic [UV_W-1:0] UV_BOTTOM = 2'd2;

    // Memory read sources during a fetch: the cell itself, then each neighbor.
    localparam logic [SRC_W-1:0] SRC_SELF   = 3'd0;
    localparam logic [SRC_W-1:0] SRC_FRONT  = 3'd1;
    localparam logic [SRC_W-1:0] SRC_BACK   = 3'd2;
    localparam logic [SRC_W-1:0] SRC_RIGHT  = 3'd3;
    localparam logic [SRC_W-1:0] SRC_LEFT   = 3'd4;
    localparam logic [SRC_W-1:0] SRC_TOP    = 3'd5;
    localparam logic [SRC_W-1:0] SRC_BOTTOM = 3'd6;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             clr_step;
        logic             item_load;
        logic             mem_write;
        logic             cnt_clear;
        logic             rd_en;
        logic [SRC_W-1:0] rd_sel;
        logic             emit_load;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_done;
        logic in_grid;
        logic pend_empty;
        logic pend_single;
        logic out_free;
    } t_dp_sts;

    // Texture set of a face.
    function automatic logic [UV_W-1:0] uv_of_face(input logic [FACE_W-1:0] face);
        logic [UV_W-1:0] uv;
        case (face)
            FACE_TOP:    uv = UV_TOP;
            FACE_BOTTOM: uv = UV_BOTTOM;
            default:     uv = UV_SIDE;
        endcase
        return uv;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/vvfe_ram.sv -----
// Generic single-port RAM with registered read data.
// Depends on nothing.
`default_nettype none

module vvfe_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 32768
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One access per cycle: a write or a registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- hw/rtl/vvfe_dp.sv -----
// Datapath of the visible-face extractor: block memory, clear counter,
// neighbor fetch, visibility mask, face counter and output register.
// Depends on vvfe_pkg, vvfe_ram and the assertion macro header.
`default_nettype none

`include "voxel_visible_face_extract_assert.svh"

module vvfe_dp #(
    parameter int GRID_WIDTH  = vvfe_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = vvfe_pkg::GRID_HEIGHT_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire vvfe_pkg::t_dp_cmd                  i_cmd_dp,
    output vvfe_pkg::t_dp_sts                       o_sts,
    input  wire logic [vvfe_pkg::XZ_W-1:0]          i_cell_x,
    input  wire logic [vvfe_pkg::Y_W-1:0]           i_cell_y,
    input  wire logic [vvfe_pkg::XZ_W-1:0]          i_cell_z,
    input  wire logic [vvfe_pkg::KIND_W-1:0]        i_block_kind,
    input  wire logic                               i_out_stall,
    output logic                                    o_out_valid,
    output logic      [vvfe_pkg::FACE_W-1:0]        o_face_id,
    output logic      [vvfe_pkg::XZ_W-1:0]          o_out_x,
    output logic      [vvfe_pkg::Y_W-1:0]           o_out_y,
    output logic      [vvfe_pkg::XZ_W-1:0]          o_out_z,
    output logic      [vvfe_pkg::KIND_W-1:0]        o_texture_index,
    output logic      [vvfe_pkg::UV_W-1:0]          o_uv_group,
    output logic      [vvfe_pkg::VBASE_W-1:0]       o_vertex_base,
    output logic                                    o_last
);

    localparam int CW     = vvfe_pkg::COORD_W;
    localparam int XZ_W   = vvfe_pkg::XZ_W;
    localparam int Y_W    = vvfe_pkg::Y_W;
    localparam int KW     = vvfe_pkg::KIND_W;
    localparam int FW     = vvfe_pkg::FACE_W;
    localparam int NF     = vvfe_pkg::NUM_FACES;
    localparam int SW     = vvfe_pkg::SRC_W;
    localparam int CNT_W  = vvfe_pkg::COUNT_W;
    // Address is the packed concatenation {z, y, x}, each padded to a power of two.
    localparam int XB     = $clog2(GRID_WIDTH);
    localparam int YB     = $clog2(GRID_HEIGHT);
    localparam int AW     = 2 * XB + YB;
    localparam int DEPTH  = 1 << AW;

    function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] x,
                                                input logic [CW-1:0] y,
                                                input logic [CW-1:0] z);
        return {z[XB-1:0], y[YB-1:0], x[XB-1:0]};
    endfunction

    logic [AW-1:0]     r_clr_addr;
    logic [XZ_W-1:0]   r_x;
    logic [Y_W-1:0]    r_y;
    logic [XZ_W-1:0]   r_z;
    logic [KW-1:0]     r_me;
    logic [NF-1:0]     r_vis;
    logic              r_cap_vld;
    logic [SW-1:0]     r_cap_sel;
    logic [CNT_W-1:0]  r_face_cnt;
    logic              r_out_valid;
    logic [FW-1:0]     r_face_id;
    logic [XZ_W-1:0]   r_out_x;
    logic [Y_W-1:0]    r_out_y;
    logic [XZ_W-1:0]   r_out_z;
    logic [KW-1:0]     r_tex;
    logic [1:0]        r_uv;
    logic [vvfe_pkg::VBASE_W-1:0] r_vbase;
    logic              r_last;

    logic [CW-1:0]     in_x;
    logic [CW-1:0]     in_y;
    logic [CW-1:0]     in_z;
    logic              in_grid;
    logic [CW-1:0]     cx;
    logic [CW-1:0]     cy;
    logic [CW-1:0]     cz;
    logic [CW-1:0]     nx;
    logic [CW-1:0]     ny;
    logic [CW-1:0]     nz;
    logic [NF-1:0]     bnd;
    logic              nb_empty;
    logic [NF-1:0]     pend;
    logic [NF-1:0]     lowbit;
    logic [FW-1:0]     sel_face;
    logic              out_free;
    logic              mem_we;
    logic [AW-1:0]     mem_addr;
    logic [KW-1:0]     mem_wdata;
    logic [KW-1:0]     mem_rdata;

    // Incoming cell coordinates and the grid range check.
    assign in_x    = CW'(i_cell_x);
    assign in_y    = CW'(i_cell_y);
    assign in_z    = CW'(i_cell_z);
    assign in_grid = (in_x < CW'(GRID_WIDTH)) && (in_y < CW'(GRID_HEIGHT))
                     && (in_z < CW'(GRID_WIDTH));

    // Held cell coordinates and which faces lie on the grid boundary.
    assign cx = CW'(r_x);
    assign cy = CW'(r_y);
    assign cz = CW'(r_z);
    assign bnd[vvfe_pkg::FACE_FRONT]  = (cz == CW'(GRID_WIDTH - 1));
    assign bnd[vvfe_pkg::FACE_BACK]   = (cz == '0);
    assign bnd[vvfe_pkg::FACE_RIGHT]  = (cx == CW'(GRID_WIDTH - 1));
    assign bnd[vvfe_pkg::FACE_LEFT]   = (cx == '0);
    assign bnd[vvfe_pkg::FACE_TOP]    = (cy == CW'(GRID_HEIGHT - 1));
    assign bnd[vvfe_pkg::FACE_BOTTOM] = (cy == '0);

    // Coordinates of the cell read in this fetch cycle. A boundary neighbor
    // reads a don't-care address whose data is ignored.
    always_comb begin
        nx = cx;
        ny = cy;
        nz = cz;
        case (i_cmd_dp.rd_sel)
            vvfe_pkg::SRC_FRONT:  nz = cz + CW'(1);
            vvfe_pkg::SRC_BACK:   nz = cz - CW'(1);
            vvfe_pkg::SRC_RIGHT:  nx = cx + CW'(1);
            vvfe_pkg::SRC_LEFT:   nx = cx - CW'(1);
            vvfe_pkg::SRC_TOP:    ny = cy + CW'(1);
            vvfe_pkg::SRC_BOTTOM: ny = cy - CW'(1);
            default: ;
        endcase
    end

    // Memory port: clearing pass, block write or fetch read.
    always_comb begin
        mem_we    = i_cmd_dp.clr_step || i_cmd_dp.mem_write;
        mem_wdata = i_cmd_dp.clr_step ? '0 : i_block_kind;
        if (i_cmd_dp.clr_step) begin
            mem_addr = r_clr_addr;
        end else if (i_cmd_dp.mem_write) begin
            mem_addr = cell_addr(in_x, in_y, in_z);
        end else begin
            mem_addr = cell_addr(nx, ny, nz);
        end
    end

    vvfe_ram #(
        .WIDTH (KW),
        .DEPTH (DEPTH)
    ) u_block_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    // Clear counter, face counter and the read-data tag that follows the registered read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_cap_vld  <= 1'b0;
            r_face_cnt <= '0;
        end else begin
            if (i_cmd_dp.clr_step) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            r_cap_vld <= i_cmd_dp.rd_en;
            if (i_cmd_dp.cnt_clear) begin
                r_face_cnt <= '0;
            end else if (i_cmd_dp.emit_load) begin
                r_face_cnt <= r_face_cnt + CNT_W'(1);
            end
        end
    end

    assign nb_empty = (mem_rdata == '0);

    // Held item, own block type and visibility mask.
    always_ff @(posedge i_clk) begin
        r_cap_sel <= i_cmd_dp.rd_sel;
        if (i_cmd_dp.item_load) begin
            r_x <= i_cell_x;
            r_y <= i_cell_y;
            r_z <= i_cell_z;
        end
        if (r_cap_vld) begin
            case (r_cap_sel)
                vvfe_pkg::SRC_SELF:   r_me <= mem_rdata;
                vvfe_pkg::SRC_FRONT:  r_vis[vvfe_pkg::FACE_FRONT] <=
                                          bnd[vvfe_pkg::FACE_FRONT] || nb_empty;
                vvfe_pkg::SRC_BACK:   r_vis[vvfe_pkg::FACE_BACK] <=
                                          bnd[vvfe_pkg::FACE_BACK] || nb_empty;
                vvfe_pkg::SRC_RIGHT:  r_vis[vvfe_pkg::FACE_RIGHT] <=
                                          bnd[vvfe_pkg::FACE_RIGHT] || nb_empty;
                vvfe_pkg::SRC_LEFT:   r_vis[vvfe_pkg::FACE_LEFT] <=
                                          bnd[vvfe_pkg::FACE_LEFT] || nb_empty;
                vvfe_pkg::SRC_TOP:    r_vis[vvfe_pkg::FACE_TOP] <=
                                          bnd[vvfe_pkg::FACE_TOP] || nb_empty;
                vvfe_pkg::SRC_BOTTOM: r_vis[vvfe_pkg::FACE_BOTTOM] <=
                                          bnd[vvfe_pkg::FACE_BOTTOM] || nb_empty;
                default: ;
            endcase
        end else if (i_cmd_dp.emit_load) begin
            r_vis <= r_vis & ~lowbit;
        end
    end

    // Faces still to emit; an empty cell has none. Lowest face goes first.
    assign pend   = (r_me != '0) ? r_vis : '0;
    assign lowbit = pend & (~pend + NF'(1));

    always_comb begin
        sel_face = '0;
        for (int i = NF - 1; i >= 0; i--) begin
            if (pend[i]) begin
                sel_face = FW'(i);
            end
        end
    end

    // Output register frees up when its transaction is taken.
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd_dp.emit_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd_dp.emit_load) begin
            r_face_id <= sel_face;
            r_out_x   <= r_x;
            r_out_y   <= r_y;
            r_out_z   <= r_z;
            r_tex     <= r_me - KW'(1);
            r_uv      <= vvfe_pkg::uv_of_face(sel_face);
            r_vbase   <= {r_face_cnt, 2'b00};
            r_last    <= ((pend & ~lowbit) == '0);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_face_id       = r_face_id;
    assign o_out_x         = r_out_x;
    assign o_out_y         = r_out_y;
    assign o_out_z         = r_out_z;
    assign o_texture_index = r_tex;
    assign o_uv_group      = r_uv;
    assign o_vertex_base   = r_vbase;
    assign o_last          = r_last;

    // Status back to the controller.
    always_comb begin
        o_sts.clr_done    = (r_clr_addr == '1);
        o_sts.in_grid     = in_grid;
        o_sts.pend_empty  = (pend == '0);
        o_sts.pend_single = (pend != '0) && ((pend & ~lowbit) == '0);
        o_sts.out_free    = out_free;
    end

    // The last pending face, once loaded, leaves nothing to emit.
    `VVFE_ASSERT_NEXT(a_last_face_drains, i_clk, i_rst_n,
        i_cmd_dp.emit_load && o_sts.pend_single, o_sts.pend_empty,
        "face mask not empty after loading the last face")
    // A loaded face is presented in the next cycle.
    `VVFE_ASSERT_NEXT(a_load_shows_valid, i_clk, i_rst_n,
        i_cmd_dp.emit_load, r_out_valid,
        "output register not valid after a face load")
    // Fetch reads never share the single port with a write.
    `VVFE_ASSERT_SAME(a_port_exclusive, i_clk, i_rst_n,
        i_cmd_dp.rd_en, !i_cmd_dp.mem_write && !i_cmd_dp.clr_step,
        "memory read and write in the same cycle")

endmodule

`default_nettype wire

// ----- hw/rtl/vvfe_ctrl.sv -----
// Controller of the visible-face extractor: clearing pass, command decode,
// neighbor fetch sequence and face emission.
// Depends on vvfe_pkg and the assertion macro header.
`default_nettype none

`include "voxel_visible_face_extract_assert.svh"

module vvfe_ctrl (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [vvfe_pkg::CMD_W-1:0]  i_cmd,
    input  wire vvfe_pkg::t_dp_sts           i_sts,
    output vvfe_pkg::t_dp_cmd                o_cmd_dp
);

    localparam int SW = vvfe_pkg::SRC_W;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_FETCH = 3'd2;
    localparam logic [2:0] S_WAIT  = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    logic [2:0]    r_state;
    logic [2:0]    n_state;
    logic [SW-1:0] r_rd_cnt;
    logic [SW-1:0] n_rd_cnt;
    logic          accept;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);

    // Next state and datapath commands.
    always_comb begin
        n_state  = r_state;
        n_rd_cnt = r_rd_cnt;
        o_cmd_dp = '0;
        o_cmd_dp.rd_sel = r_rd_cnt;
        case (r_state)
            S_CLEAR: begin
                o_cmd_dp.clr_step = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    o_cmd_dp.item_load = 1'b1;
                    case (i_cmd)
                        vvfe_pkg::CMD_WRITE: begin
                            o_cmd_dp.mem_write = i_sts.in_grid;
                        end
                        vvfe_pkg::CMD_RESTART: begin
                            o_cmd_dp.cnt_clear = 1'b1;
                        end
                        vvfe_pkg::CMD_EMIT: begin
                            if (i_sts.in_grid) begin
                                n_state  = S_FETCH;
                                n_rd_cnt = vvfe_pkg::SRC_SELF;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_FETCH: begin
                o_cmd_dp.rd_en = 1'b1;
                if (r_rd_cnt == vvfe_pkg::SRC_BOTTOM) begin
                    n_state = S_WAIT;
                end else begin
                    n_rd_cnt = r_rd_cnt + SW'(1);
                end
            end
            S_WAIT: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.pend_empty) begin
                    n_state = S_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd_dp.emit_load = 1'b1;
                    if (i_sts.pend_single) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_rd_cnt <= '0;
        end else begin
            r_state  <= n_state;
            r_rd_cnt <= n_rd_cnt;
        end
    end

    // An in-grid emit request starts the fetch sequence.
    `VVFE_ASSERT_NEXT(a_emit_starts_fetch, i_clk, i_rst_n,
        accept && (i_cmd == vvfe_pkg::CMD_EMIT) && i_sts.in_grid, r_state == S_FETCH,
        "emit request did not start a fetch")
    // A face is loaded only when one is pending and the output can take it.
    `VVFE_ASSERT_SAME(a_emit_guarded, i_clk, i_rst_n,
        o_cmd_dp.emit_load, !i_sts.pend_empty && i_sts.out_free,
        "face loaded without a pending face or a free output")
    // After the last of the seven reads the fetch moves on to the wait state.
    `VVFE_ASSERT_NEXT(a_fetch_then_wait, i_clk, i_rst_n,
        (r_state == S_FETCH) && (r_rd_cnt == vvfe_pkg::SRC_BOTTOM), r_state == S_WAIT,
        "fetch did not end after the last neighbor read")

endmodule

`default_nettype wire

// ----- hw/rtl/voxel_visible_face_extract.sv -----
// Voxel visible-face extractor, top level (uses vvfe_pkg, vvfe_ctrl, vvfe_dp,
// vvfe_ram). A grid of GRID_WIDTH x GRID_HEIGHT x GRID_WIDTH 4-bit block types
// lives in one single-port block memory. After reset the block sweeps that
// memory to empty, one entry per cycle, holding o_in_stall high until the
// sweep is done. After a write or a restart transaction the block stays idle,
// ready for the next transaction. An emit transaction for a cell inside the
// grid makes 7 memory reads (the cell and its six neighbors, one per cycle
// through the single port), waits for the last read data and then loads each
// visible face into the output register as that register frees up, holding
// o_in_stall high until the last face is loaded. Faces of a cell come out in
// the order front, back, right, left, top, bottom with o_last on the final one;
// an emit for a cell outside the grid, or for an empty cell, yields nothing.
`default_nettype none

module voxel_visible_face_extract #(
    parameter int GRID_WIDTH  = vvfe_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = vvfe_pkg::GRID_HEIGHT_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic [vvfe_pkg::CMD_W-1:0]        i_cmd,
    input  wire logic [vvfe_pkg::XZ_W-1:0]         i_cell_x,
    input  wire logic [vvfe_pkg::Y_W-1:0]          i_cell_y,
    input  wire logic [vvfe_pkg::XZ_W-1:0]         i_cell_z,
    input  wire logic [vvfe_pkg::KIND_W-1:0]       i_block_kind,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic      [vvfe_pkg::FACE_W-1:0]       o_face_id,
    output logic      [vvfe_pkg::XZ_W-1:0]         o_out_x,
    output logic      [vvfe_pkg::Y_W-1:0]          o_out_y,
    output logic      [vvfe_pkg::XZ_W-1:0]         o_out_z,
    output logic      [vvfe_pkg::KIND_W-1:0]       o_texture_index,
    output logic      [vvfe_pkg::UV_W-1:0]         o_uv_group,
    output logic      [vvfe_pkg::VBASE_W-1:0]      o_vertex_base,
    output logic                                   o_last
);

    vvfe_pkg::t_dp_cmd cmd_dp;
    vvfe_pkg::t_dp_sts sts;

    // Sequencer.
    vvfe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_cmd      (i_cmd),
        .i_sts      (sts),
        .o_cmd_dp   (cmd_dp)
    );

    // Memory, visibility logic and output register.
    vvfe_dp #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_dp        (cmd_dp),
        .o_sts           (sts),
        .i_cell_x        (i_cell_x),
        .i_cell_y        (i_cell_y),
        .i_cell_z        (i_cell_z),
        .i_block_kind    (i_block_kind),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_face_id       (o_face_id),
        .o_out_x         (o_out_x),
        .o_out_y         (o_out_y),
        .o_out_z         (o_out_z),
        .o_texture_index (o_texture_index),
        .o_uv_group      (o_uv_group),
        .o_vertex_base   (o_vertex_base),
        .o_last          (o_last)
    );

endmodule

`default_nettype wire

// ----- sim/voxel_visible_face_extract_tb.sv -----
// Self-checking testbench for the voxel visible-face extractor: a directed table
// and clustered random traffic, all checked face by face.
// Depends on vvfe_pkg and the voxel_visible_face_extract RTL.
`timescale 1ns / 100ps

module voxel_visible_face_extract_tb;

    localparam int GW = vvfe_pkg::GRID_WIDTH_DEF;
    localparam int GH = vvfe_pkg::GRID_HEIGHT_DEF;
    localparam int CELLS = GW * GW * GH;

    // Field widths of the block.
    localparam int CMD_W     = vvfe_pkg::CMD_W;
    localparam int XZ_W      = vvfe_pkg::XZ_W;
    localparam int Y_W       = vvfe_pkg::Y_W;
    localparam int KIND_W    = vvfe_pkg::KIND_W;
    localparam int FACE_W    = vvfe_pkg::FACE_W;
    localparam int UV_W      = vvfe_pkg::UV_W;
    localparam int COUNT_W   = vvfe_pkg::COUNT_W;
    localparam int VBASE_W   = vvfe_pkg::VBASE_W;
    localparam int NUM_FACES = vvfe_pkg::NUM_FACES;

    // The command code that the block ignores.
    localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;

    // The limit outlasts the reset sweep, which alone keeps both channels quiet.
    localparam int WATCHDOG_LIMIT = 100000;
    localparam int HOLD_CYCLES    = 300;
    localparam int TAIL_CYCLES    = 64;
    localparam int RANDOM_ITEMS   = 130;
    localparam int MAX_PRINTS     = 40;

    // One face as it leaves the block.
    typedef struct packed {
        logic [FACE_W-1:0]  face;
        logic [XZ_W-1:0]    x;
        logic [Y_W-1:0]     y;
        logic [XZ_W-1:0]    z;
        logic [KIND_W-1:0]  tex;
        logic [UV_W-1:0]    uv;
        logic [VBASE_W-1:0] vbase;
        logic               last;
    } t_face;

    // One input transaction; typed rows carry their own expected faces.
    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [XZ_W-1:0]    x;
        logic [Y_W-1:0]     y;
        logic [XZ_W-1:0]    z;
        logic [KIND_W-1:0]  kind;
        logic               typed;
        logic [5:0]         mask;
        logic [KIND_W-1:0]  tex;
        logic [VBASE_W-1:0] vbase;
    } t_row;

    // Directed table. mask bits are face codes: front, back, right, left, top, bottom.
    t_row directed_rows [0:18] = '{
        '{vvfe_pkg::CMD_EMIT,    4'd0,  7'd0,   4'd0,  4'd0,  1'b1, 6'b000000, 4'd0,  20'd0},
        '{vvfe_pkg::CMD_EMIT,    4'd15, 7'd127, 4'd15, 4'd0,  1'b1, 6'b000000, 4'd0,  20'd0},
        '{vvfe_pkg::CMD_WRITE,   4'd0,  7'd0,   4'd0,  4'd1,  1'b0, 6'b000000, 4'd0,  20'd0},
        '{vvfe_pkg::CMD_EMIT,    4'd0,  7'd0,   4'd0,  4'd0,  1'b1, 6'b111111, 4'd0,  20'd0},
        '{vvfe_pkg::CMD_WRITE,   4'd15, 7'd127, 4'd15, 4'd15, 1'b0, 6'b000000, 4'd0,  20'd0},
        '{vvfe_pkg::CMD_EMIT,    4'd15, 7'd127, 4'd15, 4'd0,  1'b1, 6'b111111, 4'd14, 20'd24},
        '{vvfe_pkg::CMD_RESTART, 4'd0,  7'd0,   4'd0,  4'd0,  1'b0, 6'b000000, 4'd0,  20'd0},
        '{vvfe_pkg::CMD_EMIT,    4'd15, 7'd127, 4'd15, 4'd0,  1'b1, 6'b111111, 4'd14, 20'd0},
        '{vvfe_pkg::CMD_WRITE,   4'd1,  7'd0,   4'd0,  4'd5,  1'b0, 6'b000000, 4'd0,  20'd0},
        '{vvfe_pkg::CMD_EMIT,    4'd0,  7'd0,   4'd0,  4'd0,  1'b0, 6'b000000, 4'd0,  20'd0},
        '{vvfe_pkg::CMD_EMIT,    4'd1,  7'd0,   4'd0,  4'd0,  1'b0, 6'b000000, 4'd0,  20'd0},
        '{vvfe_pkg::CMD_WRITE,   4'd0,  7'd1,   4'd0,  4'd2,  1'b0, 6'b000000, 4'd0,  20'd0},
        '{vvfe_pkg::CMD_WRITE,   4'd0,  7'd0,   4'd1,  4'd3,  1'b0, 6'b000000, 4'd0,  20'd0},
        '{vvfe_pkg::CMD_EMIT,    4'd0,  7'd0,   4'd0,  4'd0,  1'b0, 6'b000000, 4'd0,  20'd0},
        '{vvfe_pkg::CMD_WRITE,   4'd1,  7'd0,   4'd0,  4'd0,  1'b0, 6'b000000, 4'd0,  20'd0},
        '{vvfe_pkg::CMD_EMIT,    4'd0,  7'd0,   4'd0,  4'd0,  1'b0, 6'b000000, 4'd0,  20'd0},
        '{CMD_NOP,               4'd0,  7'd0,   4'd0,  4'd9,  1'b1, 6'b000000, 4'd0,  20'd0},
        '{vvfe_pkg::CMD_EMIT,    4'd0,  7'd0,   4'd0,  4'd0,  1'b0, 6'b000000, 4'd0,  20'd0},
        '{vvfe_pkg::CMD_EMIT,    4'd0,  7'd1,   4'd0,  4'd15, 1'b0, 6'b000000, 4'd0,  20'd0}
    };

    logic i_clk;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic [CMD_W-1:0] i_cmd = vvfe_pkg::CMD_WRITE;
    logic [XZ_W-1:0] i_cell_x = '0;
    logic [Y_W-1:0] i_cell_y = '0;
    logic [XZ_W-1:0] i_cell_z = '0;
    logic [KIND_W-1:0] i_block_kind = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic [FACE_W-1:0] o_face_id;
    logic [XZ_W-1:0] o_out_x;
    logic [Y_W-1:0] o_out_y;
    logic [XZ_W-1:0] o_out_z;
    logic [KIND_W-1:0] o_texture_index;
    logic [UV_W-1:0] o_uv_group;
    logic [VBASE_W-1:0] o_vertex_base;
    logic o_last;

    // Typed expectation that travels with the driven transaction.
    logic drv_typed = 1'b0;
    logic [5:0] drv_mask = '0;
    logic [KIND_W-1:0] drv_tex = '0;
    logic [VBASE_W-1:0] drv_vbase = '0;

    // Predicted block state.
    logic [KIND_W-1:0] grid_kind [CELLS];
    logic [COUNT_W-1:0] face_total = '0;

    t_face expected_faces [$];
    int error_count = 0;
    int idle_cycles = 0;
    bit no_idle = 1'b0;
    bit hold_request = 1'b0;

    voxel_visible_face_extract dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_cmd           (i_cmd),
        .i_cell_x        (i_cell_x),
        .i_cell_y        (i_cell_y),
        .i_cell_z        (i_cell_z),
        .i_block_kind    (i_block_kind),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_face_id       (o_face_id),
        .o_out_x         (o_out_x),
        .o_out_y         (o_out_y),
        .o_out_z         (o_out_z),
        .o_texture_index (o_texture_index),
        .o_uv_group      (o_uv_group),
        .o_vertex_base   (o_vertex_base),
        .o_last          (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int idle_draw();
        return no_idle ? 0 : int'($urandom_range(0, 15));
    endfunction

    function automatic bit in_grid(input int x, input int y, input int z);
        return x >= 0 && x < GW && y >= 0 && y < GH && z >= 0 && z < GW;
    endfunction

    // Block type of a cell; anything outside the grid reads as empty.
    function automatic logic [KIND_W-1:0] kind_at(input int x, input int y, input int z);
        return in_grid(x, y, z) ? grid_kind[x + y * GW + z * GW * GH] : '0;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want_v);
        error_count++;
        if (error_count <= MAX_PRINTS) begin
            $display("MISMATCH at %0t: %s got %0d, expected %0d", $realtime, what, got, want_v);
        end
    endtask

    // Applies one accepted transaction to the predicted state and returns the
    // visible-face set, the texture index and the first vertex base.
    task automatic predict_transaction(
        input  logic [CMD_W-1:0]   cmd,
        input  logic [XZ_W-1:0]    x,
        input  logic [Y_W-1:0]     y,
        input  logic [XZ_W-1:0]    z,
        input  logic [KIND_W-1:0]  kind,
        output logic [5:0]         mask,
        output logic [KIND_W-1:0]  tex,
        output logic [VBASE_W-1:0] vbase
    );
        int cx;
        int cy;
        int cz;
        logic [KIND_W-1:0] self_kind;
        cx = int'(x);
        cy = int'(y);
        cz = int'(z);
        mask = '0;
        tex = '0;
        vbase = {face_total, 2'b00};
        case (cmd)
            vvfe_pkg::CMD_WRITE: begin
                if (in_grid(cx, cy, cz)) begin
                    grid_kind[cx + cy * GW + cz * GW * GH] = kind;
                end
            end
            vvfe_pkg::CMD_RESTART: begin
                face_total = '0;
            end
            vvfe_pkg::CMD_EMIT: begin
                self_kind = kind_at(cx, cy, cz);
                if (in_grid(cx, cy, cz) && self_kind != '0) begin
                    tex = self_kind - 1'b1;
                    mask[vvfe_pkg::FACE_FRONT]  = (cz == GW - 1)
                                                  || kind_at(cx, cy, cz + 1) == '0;
                    mask[vvfe_pkg::FACE_BACK]   = (cz == 0) || kind_at(cx, cy, cz - 1) == '0;
                    mask[vvfe_pkg::FACE_RIGHT]  = (cx == GW - 1)
                                                  || kind_at(cx + 1, cy, cz) == '0;
                    mask[vvfe_pkg::FACE_LEFT]   = (cx == 0) || kind_at(cx - 1, cy, cz) == '0;
                    mask[vvfe_pkg::FACE_TOP]    = (cy == GH - 1)
                                                  || kind_at(cx, cy + 1, cz) == '0;
                    mask[vvfe_pkg::FACE_BOTTOM] = (cy == 0) || kind_at(cx, cy - 1, cz) == '0;
                    face_total = face_total + COUNT_W'($countones(mask));
                end
            end
            default: begin
            end
        endcase
    endtask

    // Queues one expected face per set bit, in face order, four vertices apart.
    task automatic list_faces(
        input logic [5:0]         mask,
        input logic [XZ_W-1:0]    x,
        input logic [Y_W-1:0]     y,
        input logic [XZ_W-1:0]    z,
        input logic [KIND_W-1:0]  tex,
        input logic [VBASE_W-1:0] vbase
    );
        t_face f;
        int i;
        int last_face;
        last_face = -1;
        for (i = 0; i < NUM_FACES; i++) begin
            if (mask[i]) last_face = i;
        end
        for (i = 0; i < NUM_FACES; i++) begin
            if (mask[i]) begin
                f.face = FACE_W'(i);
                f.x = x;
                f.y = y;
                f.z = z;
                f.tex = tex;
                if (f.face == vvfe_pkg::FACE_TOP) f.uv = vvfe_pkg::UV_TOP;
                else if (f.face == vvfe_pkg::FACE_BOTTOM) f.uv = vvfe_pkg::UV_BOTTOM;
                else f.uv = vvfe_pkg::UV_SIDE;
                f.vbase = vbase;
                f.last = (i == last_face);
                vbase = vbase + VBASE_W'(4);
                expected_faces = {expected_faces, f};
            end
        end
    endtask

    // Offers one input transaction after a random gap and holds it until taken.
    task automatic send_row(input t_row r);
        int gap;
        gap = idle_draw();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd <= r.cmd;
        i_cell_x <= r.x;
        i_cell_y <= r.y;
        i_cell_z <= r.z;
        i_block_kind <= r.kind;
        drv_typed <= r.typed;
        drv_mask <= r.mask;
        drv_tex <= r.tex;
        drv_vbase <= r.vbase;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // Output side: a random stall before each face, one long hold on request.
    initial begin : receiver
        int hold;
        @(posedge i_rst_n);
        forever begin
            if (hold_request) begin
                hold = HOLD_CYCLES;
                hold_request = 1'b0;
            end else begin
                hold = idle_draw();
            end
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // Checks accepted faces, predicts accepted commands and watches for a hang.
    always @(posedge i_clk) begin : monitor
        t_face want;
        logic [5:0] mask;
        logic [KIND_W-1:0] tex;
        logic [VBASE_W-1:0] vbase;
        logic moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (o_out_valid && !i_out_stall) begin
                moved = 1'b1;
                if (expected_faces.size() == 0) begin
                    report_mismatch("unexpected face, face_id", int'(o_face_id), -1);
                end else begin
                    want = expected_faces.pop_front();
                    if (o_face_id != want.face)
                        report_mismatch("face_id", int'(o_face_id), int'(want.face));
                    if (o_out_x != want.x)
                        report_mismatch("out_x", int'(o_out_x), int'(want.x));
                    if (o_out_y != want.y)
                        report_mismatch("out_y", int'(o_out_y), int'(want.y));
                    if (o_out_z != want.z)
                        report_mismatch("out_z", int'(o_out_z), int'(want.z));
                    if (o_texture_index != want.tex)
                        report_mismatch("texture_index", int'(o_texture_index), int'(want.tex));
                    if (o_uv_group != want.uv)
                        report_mismatch("uv_group", int'(o_uv_group), int'(want.uv));
                    if (o_vertex_base != want.vbase)
                        report_mismatch("vertex_base", int'(o_vertex_base), int'(want.vbase));
                    if (o_last != want.last)
                        report_mismatch("last", int'(o_last), int'(want.last));
                end
            end
            if (i_in_valid && !o_in_stall) begin
                moved = 1'b1;
                predict_transaction(i_cmd, i_cell_x, i_cell_y, i_cell_z, i_block_kind,
                                    mask, tex, vbase);
                if (drv_typed) list_faces(drv_mask, i_cell_x, i_cell_y, i_cell_z, drv_tex,
                                          drv_vbase);
                else list_faces(mask, i_cell_x, i_cell_y, i_cell_z, tex, vbase);
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Stimulus: directed table, then clustered random traffic.
    initial begin : stimulus
        t_row r;
        int i;
        int bx;
        int by;
        int bz;
        int sel;
        foreach (grid_kind[k]) grid_kind[k] = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k]) send_row(directed_rows[k]);

        // Random traffic in small boxes so neighbors are often occupied.
        hold_request = 1'b1;
        bx = 0;
        by = 0;
        bz = 0;
        for (i = 0; i < RANDOM_ITEMS; i++) begin
            no_idle = (i >= 60 && i < 100);
            if (i % 20 == 0) begin
                sel = $urandom_range(0, 2);
                bx = (sel == 0) ? 0 : (sel == 1) ? GW - 3 : int'($urandom_range(0, GW - 3));
                sel = $urandom_range(0, 2);
                by = (sel == 0) ? 0 : (sel == 1) ? GH - 3 : int'($urandom_range(0, GH - 3));
                sel = $urandom_range(0, 2);
                bz = (sel == 0) ? 0 : (sel == 1) ? GW - 3 : int'($urandom_range(0, GW - 3));
            end
            r = '0;
            if ($urandom_range(0, 9) == 0) begin
                r.x = XZ_W'($urandom);
                r.y = Y_W'($urandom);
                r.z = XZ_W'($urandom);
            end else begin
                r.x = XZ_W'(bx + int'($urandom_range(0, 2)));
                r.y = Y_W'(by + int'($urandom_range(0, 2)));
                r.z = XZ_W'(bz + int'($urandom_range(0, 2)));
            end
            sel = $urandom_range(0, 99);
            if (sel < 45) begin
                r.cmd = vvfe_pkg::CMD_WRITE;
                r.kind = ($urandom_range(0, 3) == 0) ? '0 : KIND_W'($urandom_range(1, 15));
            end else begin
                if (sel < 90) r.cmd = vvfe_pkg::CMD_EMIT;
                else if (sel < 95) r.cmd = vvfe_pkg::CMD_RESTART;
                else r.cmd = CMD_NOP;
                r.kind = KIND_W'($urandom);
            end
            send_row(r);
        end
        i_in_valid <= 1'b0;

        // Drain, then give any stray face time to show up.
        @(posedge i_clk);
        while (expected_faces.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/vvfe_pkg.sv
hw/rtl/vvfe_ram.sv
hw/rtl/vvfe_dp.sv
hw/rtl/vvfe_ctrl.sv
hw/rtl/voxel_visible_face_extract.sv
sim/voxel_visible_face_extract_tb.sv
